[sv/coordinate_keyed_tile_table_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tile table
// Implication checks on a clock with a synchronous active-high reset.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_KEYED_TILE_TABLE_ASSERT_SVH
`define COORDINATE_KEYED_TILE_TABLE_ASSERT_SVH

// same-cycle implication
`define CKT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CKT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/ckt_pkg.sv]
// ----------------------------------------------------------------------------
// ckt_pkg
// Shared constants, codes and control types of the tile table.
// ----------------------------------------------------------------------------
package ckt_pkg;

   localparam int ENTRIES    = 256;
   localparam int COORD_BITS = 10;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = IDX_W + 1;
   localparam int COORD_LIM  = 1 << COORD_BITS;
   localparam int CSR_W      = 11;
   localparam int PROD_W     = COORD_BITS + 9;

   localparam logic [2:0] REQ_SET   = 3'd0;
   localparam logic [2:0] REQ_CLEAR = 3'd1;
   localparam logic [2:0] REQ_GET   = 3'd2;
   localparam logic [2:0] REQ_FILL  = 3'd3;
   localparam logic [2:0] REQ_RESET = 3'd4;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_OUTSIDE = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic [1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TILE_SIZE  = 2'd2;

   typedef struct packed {
      logic       load;
      logic       scan_clr;
      logic       scan;
      logic       rect;
      logic       fill_init;
      logic       next_cell;
      logic       write_upd;
      logic       write_new;
      logic       clear_ent;
      logic       clr_all;
      logic       rd_id;
      logic       rsp_load;
      logic [1:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       in_map;
      logic       fill_empty;
      logic       scan_done;
      logic       match;
      logic       free;
      logic       last_cell;
      logic       rsp_free;
   } stat_type;

endpackage

[sv/ckt_ctrl.sv]
// ----------------------------------------------------------------------------
// ckt_ctrl
// Request sequencer: decode, table scans, fill walk and response handoff.
// ----------------------------------------------------------------------------
module ckt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ckt_pkg::stat_type  stat,
   output ckt_pkg::cmd_type   cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_SCAN   = 6'b000100,
      S_UPD    = 6'b001000,
      S_WALK   = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.rsp_status = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               status_in = ckt_pkg::ST_DONE;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               ckt_pkg::REQ_SET: begin
                  if (!stat.in_map) begin
                     status_in = ckt_pkg::ST_OUTSIDE;
                     state_in  = S_RESP;
                  end else begin
                     cmd.scan_clr = 1'b1;
                     state_in     = S_SCAN;
                  end
               end
               ckt_pkg::REQ_CLEAR, ckt_pkg::REQ_GET: begin
                  cmd.scan_clr = 1'b1;
                  state_in     = S_SCAN;
               end
               ckt_pkg::REQ_FILL: begin
                  if (stat.fill_empty) begin
                     state_in = S_RESP;
                  end else begin
                     cmd.scan_clr = 1'b1;
                     state_in     = S_UPD;
                  end
               end
               ckt_pkg::REQ_RESET: begin
                  cmd.clr_all = 1'b1;
                  state_in    = S_RESP;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_RESP;
               case (stat.op)
                  ckt_pkg::REQ_SET: begin
                     if (stat.match) cmd.write_upd = 1'b1;
                     else if (stat.free) cmd.write_new = 1'b1;
                     else status_in = ckt_pkg::ST_FULL;
                  end
                  ckt_pkg::REQ_CLEAR: cmd.clear_ent = stat.match;
                  ckt_pkg::REQ_GET:   cmd.rd_id = 1'b1;
                  default: ;
               endcase
            end
         end
         S_UPD: begin
            cmd.scan = 1'b1;
            cmd.rect = 1'b1;
            if (stat.scan_done) begin
               cmd.fill_init = 1'b1;
               cmd.scan_clr  = 1'b1;
               state_in      = S_WALK;
            end
         end
         S_WALK: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               if (stat.match || stat.free) begin
                  cmd.write_new = !stat.match;
                  if (stat.last_cell) begin
                     state_in = S_RESP;
                  end else begin
                     cmd.next_cell = 1'b1;
                     cmd.scan_clr  = 1'b1;
                  end
               end else begin
                  status_in = ckt_pkg::ST_FULL;
                  state_in  = S_RESP;
               end
            end
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ckt_pkg::ST_DONE;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

[sv/ckt_dpath.sv]
// ----------------------------------------------------------------------------
// ckt_dpath
// Entry storage, scan compare, fill cursor, world multiply and result register.
// ----------------------------------------------------------------------------
module ckt_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [ckt_pkg::CSR_W-1:0] csr_wdata,
   input  logic [2:0]                req_type,
   input  logic signed [11:0]        req_grid_x,
   input  logic signed [11:0]        req_grid_y,
   input  logic signed [11:0]        req_corner_x,
   input  logic signed [11:0]        req_corner_y,
   input  logic [31:0]               req_tile_id,
   input  logic                      req_collidable,
   input  ckt_pkg::cmd_type          cmd,
   output ckt_pkg::stat_type         stat,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_found,
   output logic [31:0]               rsp_found_id,
   output logic                      rsp_found_collidable,
   output logic [17:0]               rsp_world_x,
   output logic [17:0]               rsp_world_y,
   output logic [1:0]                rsp_status
);

   localparam int CB = ckt_pkg::COORD_BITS;
   localparam int IW = ckt_pkg::IDX_W;
   localparam int PW = ckt_pkg::PROD_W;

   logic [10:0] width_ff, height_ff;
   logic [8:0]  tsize_ff;

   logic [2:0]    op_ff;
   logic [31:0]   id_ff;
   logic          sol_ff;
   logic [CB-1:0] kx_ff, ky_ff, x0_ff, x1_ff, y0_ff, y1_ff;
   logic          key_ok_ff, in_map_ff, empty_ff;

   logic [ckt_pkg::CNT_W-1:0] addr_ff;
   logic          rd_vld_ff, vbit_ff;
   logic [IW-1:0] rd_idx_ff, match_idx_ff, free_idx_ff;
   logic [CB-1:0] col_ff, row_ff;
   logic          match_ff, free_ff;

   logic [ckt_pkg::ENTRIES-1:0] valid_ff;
   logic [2*CB-1:0] key_mem [ckt_pkg::ENTRIES];
   logic [32:0]     id_mem  [ckt_pkg::ENTRIES];
   logic [32:0]     idq_ff;
   logic [PW-1:0]   px_ff, py_ff;

   logic          rsp_valid_ff, found_ff, fsol_ff;
   logic [31:0]   fid_ff;
   logic [17:0]   wx_ff, wy_ff;
   logic [1:0]    status_ff;

   // request decode
   logic signed [12:0] gx, gy, cx, cy, lim, bw, bh;
   logic signed [12:0] lox, hix, loy, hiy, x0s, x1s, y0s, y1s;
   logic [11:0]        bw_u, bh_u;

   always_comb begin
      gx   = {req_grid_x[11], req_grid_x};
      gy   = {req_grid_y[11], req_grid_y};
      cx   = {req_corner_x[11], req_corner_x};
      cy   = {req_corner_y[11], req_corner_y};
      lim  = 13'(ckt_pkg::COORD_LIM);
      bw_u = ({1'b0, width_ff} > 12'(ckt_pkg::COORD_LIM)) ?
             12'(ckt_pkg::COORD_LIM) : {1'b0, width_ff};
      bh_u = ({1'b0, height_ff} > 12'(ckt_pkg::COORD_LIM)) ?
             12'(ckt_pkg::COORD_LIM) : {1'b0, height_ff};
      bw   = $signed({1'b0, bw_u});
      bh   = $signed({1'b0, bh_u});
      lox  = (gx < cx) ? gx : cx;
      hix  = (gx < cx) ? cx : gx;
      loy  = (gy < cy) ? gy : cy;
      hiy  = (gy < cy) ? cy : gy;
      x0s  = (lox < 13'sd0) ? 13'sd0 : lox;
      y0s  = (loy < 13'sd0) ? 13'sd0 : loy;
      x1s  = (hix > bw - 13'sd1) ? bw - 13'sd1 : hix;
      y1s  = (hiy > bh - 13'sd1) ? bh - 13'sd1 : hiy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd64;
         height_ff <= 11'd64;
         tsize_ff  <= 9'd16;
      end else if (csr_we) begin
         case (csr_index)
            ckt_pkg::CSR_MAP_WIDTH:  width_ff  <= csr_wdata;
            ckt_pkg::CSR_MAP_HEIGHT: height_ff <= csr_wdata;
            ckt_pkg::CSR_TILE_SIZE:  tsize_ff  <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_type;
         id_ff     <= req_tile_id;
         sol_ff    <= req_collidable;
         kx_ff     <= gx[CB-1:0];
         ky_ff     <= gy[CB-1:0];
         key_ok_ff <= (gx >= 13'sd0) && (gx < lim) && (gy >= 13'sd0) && (gy < lim);
         in_map_ff <= (gx >= 13'sd0) && (gx < bw) && (gy >= 13'sd0) && (gy < bh);
         empty_ff  <= (x0s > x1s) || (y0s > y1s);
         x0_ff     <= x0s[CB-1:0];
         x1_ff     <= x1s[CB-1:0];
         y0_ff     <= y0s[CB-1:0];
         y1_ff     <= y1s[CB-1:0];
      end else if (cmd.fill_init) begin
         kx_ff     <= x0_ff;
         ky_ff     <= y0_ff;
         key_ok_ff <= 1'b1;
      end else if (cmd.next_cell) begin
         if (kx_ff == x1_ff) begin
            kx_ff <= x0_ff;
            ky_ff <= ky_ff + 1'b1;
         end else begin
            kx_ff <= kx_ff + 1'b1;
         end
      end
   end

   // scan pipeline: address, registered read, compare
   logic rect_hit, pt_hit;

   always_comb begin
      pt_hit   = rd_vld_ff && !cmd.rect && vbit_ff && key_ok_ff &&
                 (col_ff == kx_ff) && (row_ff == ky_ff);
      rect_hit = rd_vld_ff && cmd.rect && vbit_ff &&
                 (col_ff >= x0_ff) && (col_ff <= x1_ff) &&
                 (row_ff >= y0_ff) && (row_ff <= y1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
         match_ff  <= 1'b0;
         free_ff   <= 1'b0;
      end else if (cmd.scan_clr) begin
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
         match_ff  <= 1'b0;
         free_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan && !addr_ff[IW];
         if (cmd.scan && !addr_ff[IW]) addr_ff <= addr_ff + 1'b1;
         if (pt_hit && !match_ff) match_ff <= 1'b1;
         if (rd_vld_ff && !vbit_ff && !free_ff) free_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      {row_ff, col_ff} <= key_mem[addr_ff[IW-1:0]];
      vbit_ff          <= valid_ff[addr_ff[IW-1:0]];
      rd_idx_ff        <= addr_ff[IW-1:0];
      if (pt_hit && !match_ff) match_idx_ff <= rd_idx_ff;
      if (rd_vld_ff && !vbit_ff && !free_ff) free_idx_ff <= rd_idx_ff;
   end

   // entry storage
   logic          id_we;
   logic [IW-1:0] id_waddr;

   always_comb begin
      id_we    = rect_hit || cmd.write_upd || cmd.write_new;
      id_waddr = rect_hit ? rd_idx_ff : (cmd.write_upd ? match_idx_ff : free_idx_ff);
   end

   always_ff @(posedge clock) begin
      if (id_we) id_mem[id_waddr] <= {sol_ff, id_ff};
      if (cmd.rd_id) idq_ff <= id_mem[match_idx_ff];
      if (cmd.write_new) key_mem[free_idx_ff] <= {ky_ff, kx_ff};
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_all) begin
         valid_ff <= '0;
      end else if (cmd.write_new) begin
         valid_ff[free_idx_ff] <= 1'b1;
      end else if (cmd.clear_ent) begin
         valid_ff[match_idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= PW'(kx_ff) * PW'(tsize_ff);
      py_ff <= PW'(ky_ff) * PW'(tsize_ff);
   end

   // result register
   logic hit_get;
   assign hit_get = (op_ff == ckt_pkg::REQ_GET) && match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         found_ff  <= match_ff &&
                      ((op_ff == ckt_pkg::REQ_GET) || (op_ff == ckt_pkg::REQ_CLEAR));
         fid_ff    <= hit_get ? idq_ff[31:0] : 32'd0;
         fsol_ff   <= hit_get && idq_ff[32];
         wx_ff     <= !hit_get ? 18'd0 : ((|px_ff[PW-1:18]) ? '1 : px_ff[17:0]);
         wy_ff     <= !hit_get ? 18'd0 : ((|py_ff[PW-1:18]) ? '1 : py_ff[17:0]);
         status_ff <= cmd.rsp_status;
      end
   end

   always_comb begin
      stat.op         = op_ff;
      stat.in_map     = in_map_ff;
      stat.fill_empty = empty_ff;
      stat.scan_done  = addr_ff[IW] && !rd_vld_ff;
      stat.match      = match_ff;
      stat.free       = free_ff;
      stat.last_cell  = (kx_ff == x1_ff) && (ky_ff == y1_ff);
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = found_ff;
   assign rsp_found_id         = fid_ff;
   assign rsp_found_collidable = fsol_ff;
   assign rsp_world_x          = wx_ff;
   assign rsp_world_y          = wy_ff;
   assign rsp_status           = status_ff;

endmodule

[sv/coordinate_keyed_tile_table.sv]
// ----------------------------------------------------------------------------
// coordinate_keyed_tile_table
// Sparse tile table keyed by grid cell with set, clear, get, fill and reset.
// ----------------------------------------------------------------------------
// Usage: one request item enters on req_* (valid/ready) and gives exactly one
// result item on rsp_* (valid/ready). Map width, map height and tile size are
// written through csr_we/csr_index/csr_wdata while the block is idle.
// A set, clear or get scans all ENTRIES slots through the one key memory read
// port, one slot a cycle; the next item is taken only once its result has gone
// to the output register. A fill scans the table once to update cells already
// present, then once per cell it walks in row-major order; the walk stops at
// the first cell that finds no free slot. Reset requests, a set outside the
// map, an empty fill and unknown requests give their result without a scan.
// The reset input empties the table at once, restores the register defaults
// (64, 64, 16) and leaves the block ready the next cycle. A finished result
// sits in the output register; the next item is accepted while it waits, and
// its own result holds until rsp_ready takes the earlier one.
// ----------------------------------------------------------------------------
`include "coordinate_keyed_tile_table_assert.svh"

module coordinate_keyed_tile_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [ckt_pkg::CSR_W-1:0] csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_type,
   input  logic signed [11:0]        req_grid_x,
   input  logic signed [11:0]        req_grid_y,
   input  logic signed [11:0]        req_corner_x,
   input  logic signed [11:0]        req_corner_y,
   input  logic [31:0]               req_tile_id,
   input  logic                      req_collidable,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_found,
   output logic [31:0]               rsp_found_id,
   output logic                      rsp_found_collidable,
   output logic [17:0]               rsp_world_x,
   output logic [17:0]               rsp_world_y,
   output logic [1:0]                rsp_status
);

   ckt_pkg::cmd_type  cmd;
   ckt_pkg::stat_type stat;

   ckt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ckt_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_type             (req_type),
      .req_grid_x           (req_grid_x),
      .req_grid_y           (req_grid_y),
      .req_corner_x         (req_corner_x),
      .req_corner_y         (req_corner_y),
      .req_tile_id          (req_tile_id),
      .req_collidable       (req_collidable),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_found            (rsp_found),
      .rsp_found_id         (rsp_found_id),
      .rsp_found_collidable (rsp_found_collidable),
      .rsp_world_x          (rsp_world_x),
      .rsp_world_y          (rsp_world_y),
      .rsp_status           (rsp_status)
   );

   `CKT_ASSERT_NEXT(a_busy_after_accept, clock, reset,
                    req_valid && req_ready, !req_ready, "ready after accept")
   `CKT_ASSERT_SAME(a_rsp_from_load, clock, reset,
                    $rose(rsp_valid), $past(cmd.rsp_load), "result without load")
   `CKT_ASSERT_SAME(a_found_done, clock, reset,
                    rsp_valid && rsp_found, rsp_status == ckt_pkg::ST_DONE,
                    "found with bad status")

endmodule
